@@ src/mcht_pkg.sv @@
// Package for the monotone convex hull trick block.
// Constants and payload structs; no dependencies.
package mcht_pkg;
   localparam int MAX_LINES = 1024;
   localparam int IDX_W = $clog2(MAX_LINES);
   localparam int CNT_W = IDX_W + 1;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               command;
      logic signed [31:0] slope;
      logic signed [63:0] intercept;
      logic signed [31:0] tag;
      logic signed [31:0] point;
   } req_type;

   typedef struct packed {
      logic signed [63:0] best_value;
      logic signed [31:0] best_tag;
      logic [1:0]         status;
   } rsp_type;

   // one line as stored
   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [63:0] intercept;
      logic signed [31:0] tag;
   } line_type;
endpackage

@@ src/mcht_if.sv @@
// Valid/ready channel carrying one payload type.
// Depends on mcht_pkg.
interface mcht_req_if (input logic clock);
   import mcht_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mcht_rsp_if (input logic clock);
   import mcht_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/mcht_mul.sv @@
// Shared 33x33 signed multiplier, registered output.
// Depends on mcht_pkg.
module mcht_mul (
   input  logic                clock,
   input  logic signed [32:0]  a,
   input  logic signed [32:0]  b,
   output logic signed [65:0]  p
);
   import mcht_pkg::*;
   logic signed [65:0] p_ff;
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end
   assign p = p_ff;
endmodule

@@ src/mcht_store.sv @@
// Line ring memory: one write port, one registered read port.
// Depends on mcht_pkg.
module mcht_store (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [mcht_pkg::IDX_W-1:0] wr_addr,
   input  mcht_pkg::line_type      wr_data,
   input  logic [mcht_pkg::IDX_W-1:0] rd_addr,
   output mcht_pkg::line_type      rd_data
);
   import mcht_pkg::*;
   line_type mem [MAX_LINES];
   line_type rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

@@ src/monotone_convex_hull_trick.sv @@
// Monotone convex hull trick (max queries), top level.
// Depends on mcht_pkg, mcht_if, mcht_mul and mcht_store.
//
// Usage: one item on req (valid/ready) yields exactly one item on rsp.
// command=0 adds a line (slope, intercept, tag); command=1 queries the
// maximum at point. Lines live in a ring of MAX_LINES entries.
// Every step runs on one 33x33 multiplier with registered output
// and one memory read port. An add reads the two tail lines, forms two cross
// products and compares, once more per tail pop (no reads when fewer than two
// lines are stored); a query reads and values the two head lines, once more
// per head pop; a query on an empty store answers without a read.
// Pops are amortized to at most one per added line.
// The ready signal is high only while the sequencer is idle.
// Wide cross products (65x33 bits) are built from two 33x33 partials.
// Reset (synchronous, active high) empties the store at once; the line
// memory itself is not cleared since unwritten entries never reach a result.
// A stalled rsp holds the result in its register; no new item is taken
// until it has been delivered.
module monotone_convex_hull_trick (
   input  logic        clock,
   input  logic        reset,
   mcht_req_if.sink    req,
   mcht_rsp_if.source  rsp
);
   import mcht_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_RD_B  = 13'b0000000000010, // read tail line b (or head line 0)
      S_RD_A  = 13'b0000000000100, // read a (or head line 1)
      S_CAP_A = 13'b0000000001000,
      S_M1    = 13'b0000000010000, // n1 lo x d2
      S_M2    = 13'b0000000100000, // n1 hi x d2
      S_M3    = 13'b0000001000000, // n2 lo x d1
      S_M4    = 13'b0000010000000, // n2 hi x d1
      S_CMP   = 13'b0000100000000,
      S_QV0   = 13'b0001000000000, // value of line 0
      S_QV1   = 13'b0010000000000, // value of line 1
      S_QCMP  = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in, k_ff, k_in;
   line_type lb_ff, lb_in, la_ff, la_in;
   logic signed [97:0] acc_ff, acc_in;   // first product / value
   logic signed [97:0] pr_ff, pr_in;     // second product
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic wr_en;
   line_type rd_data, wr_data;
   logic signed [32:0] ma, mb;
   logic signed [65:0] mp;

   mcht_store u_store (.clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);
   mcht_mul   u_mul (.clock, .a(ma), .b(mb), .p(mp));

   // exact differences (signed, one bit wider)
   logic signed [32:0] d1, d2;
   logic signed [64:0] n1, n2;
   assign d1 = 33'(cur_ff.slope) - 33'(lb_ff.slope);
   assign d2 = 33'(lb_ff.slope) - 33'(la_ff.slope);
   assign n1 = 65'(lb_ff.intercept) - 65'(cur_ff.intercept);
   assign n2 = 65'(la_ff.intercept) - 65'(lb_ff.intercept);

   // normalized: crossing = n/d with d>=0
   logic signed [64:0] n1s, n2s;
   logic signed [32:0] d1s, d2s;
   assign n1s = d1[32] ? -n1 : n1;
   assign d1s = d1[32] ? -d1 : d1;
   assign n2s = d2[32] ? -n2 : n2;
   assign d2s = d2[32] ? -d2 : d2;

   logic [CNT_W-1:0] k_m1, k_m2;
   assign k_m1 = k_ff - CNT_W'(1);
   assign k_m2 = k_ff - CNT_W'(2);

   logic signed [97:0] val_full;
   assign val_full = 98'(mp) + 98'(lb_ff.intercept);

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      head_in = head_ff;
      count_in = count_ff;
      k_in = k_ff;
      lb_in = lb_ff;
      la_in = la_ff;
      acc_in = acc_ff;
      pr_in = pr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      rd_addr = head_ff;
      wr_en = 1'b0;
      wr_addr = head_ff + k_ff[IDX_W-1:0];
      wr_data = '{slope: cur_ff.slope, intercept: cur_ff.intercept, tag: cur_ff.tag};
      ma = '0;
      mb = '0;
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && !rsp_valid_ff) begin
               cur_in = req.data;
               k_in = count_ff;
               if (req.data.command == CMD_ADD) begin
                  state_in = (count_ff >= CNT_W'(2)) ? S_RD_B : S_CMP;
               end else if (count_ff == '0) begin
                  rsp_in = '{best_value: '0, best_tag: '0, status: STATUS_EMPTY};
                  state_in = S_OUT;
               end else begin
                  state_in = S_RD_B;
               end
            end
         end
         S_RD_B: begin
            rd_addr = (cur_ff.command == CMD_ADD) ? head_ff + k_m1[IDX_W-1:0] : head_ff;
            state_in = S_RD_A;
         end
         S_RD_A: begin
            rd_addr = (cur_ff.command == CMD_ADD) ? head_ff + k_m2[IDX_W-1:0]
                                                  : head_ff + IDX_W'(1);
            lb_in = rd_data;
            state_in = S_CAP_A;
         end
         S_CAP_A: begin
            la_in = rd_data;
            state_in = (cur_ff.command == CMD_ADD) ? S_M1 : S_QV0;
         end
         S_M1: begin
            ma = {1'b0, n1s[31:0]};
            mb = d2s;
            state_in = S_M2;
         end
         S_M2: begin
            ma = n1s[64:32];
            mb = d2s;
            acc_in = 98'($unsigned(mp[63:0]));
            state_in = S_M3;
         end
         S_M3: begin
            ma = {1'b0, n2s[31:0]};
            mb = d1s;
            acc_in = acc_ff + (98'(mp) <<< 32);
            state_in = S_M4;
         end
         S_M4: begin
            ma = n2s[64:32];
            mb = d1s;
            pr_in = 98'($unsigned(mp[63:0]));
            state_in = S_CMP;
         end
         S_CMP: begin
            // n1/d1 <= n2/d2  <=>  n1*d2 <= n2*d1 (both d>0)
            logic dom;
            logic signed [97:0] q;
            q = pr_ff + (98'(mp) <<< 32);
            if (k_ff < CNT_W'(2)) dom = 1'b0;
            else if (d1 == '0) dom = (d2 == '0);
            else if (d2 == '0) dom = 1'b1;
            else dom = (acc_ff <= q);
            if (dom) begin
               k_in = k_m1;
               state_in = (k_m1 >= CNT_W'(2)) ? S_RD_B : S_CMP;
            end else if (k_ff >= CNT_W'(MAX_LINES)) begin
               rsp_in = '{best_value: '0, best_tag: '0, status: STATUS_FULL};
               state_in = S_OUT;
            end else begin
               wr_en = 1'b1;
               count_in = k_ff + CNT_W'(1);
               rsp_in = '{best_value: '0, best_tag: '0, status: STATUS_OK};
               state_in = S_OUT;
            end
         end
         S_QV0: begin
            ma = 33'(lb_ff.slope);
            mb = 33'(cur_ff.point);
            state_in = S_QV1;
         end
         S_QV1: begin
            ma = 33'(la_ff.slope);
            mb = 33'(cur_ff.point);
            acc_in = val_full;
            state_in = S_QCMP;
         end
         S_QCMP: begin
            logic signed [97:0] v1;
            v1 = 98'(mp) + 98'(la_ff.intercept);
            if (count_ff >= CNT_W'(2) && acc_ff <= v1) begin
               head_in = head_ff + IDX_W'(1);
               count_in = count_ff - CNT_W'(1);
               lb_in = la_ff;
               acc_in = v1;
               if (count_ff >= CNT_W'(3)) begin
                  k_in = CNT_W'(0);
                  state_in = S_RD_A; // reads new head+1 next
               end else begin
                  rsp_in = '{best_value: v1[63:0], best_tag: la_ff.tag, status: STATUS_OK};
                  state_in = S_OUT;
               end
            end else begin
               rsp_in = '{best_value: acc_ff[63:0], best_tag: lb_ff.tag,
                          status: STATUS_OK};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // after a head pop the head line stays in lb; skip its reread
      if (state_ff == S_RD_A && cur_ff.command == CMD_QUERY && k_ff == '0) begin
         lb_in = lb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      k_ff <= k_in;
      lb_ff <= lb_in;
      la_ff <= la_in;
      acc_ff <= acc_in;
      pr_ff <= pr_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LINES)) else $error("line count overflow");
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("busy while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed under stall");
endmodule

@@ test/monotone_convex_hull_trick_test.sv @@
`timescale 1ns / 1ps
// Testbench for monotone_convex_hull_trick: random valid/ready traffic with its own hull predictor.
// Depends on mcht_pkg, mcht_if and the block's RTL.
module monotone_convex_hull_trick_test;
   import mcht_pkg::*;

   localparam int IDLE_LIMIT = 100000;   // one item may pop ~1000 lines
   localparam int TAIL_WAIT  = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mcht_req_if req_ch (clock);
   mcht_rsp_if rsp_ch (clock);

   monotone_convex_hull_trick DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // ---------------------------------------------------------------------
   // hull predictor: ring of lines, head and count
   // ---------------------------------------------------------------------
   line_type    hull_lines [MAX_LINES];
   int unsigned hull_head  = 0;
   int unsigned hull_count = 0;

   req_type pending_items [$];
   rsp_type expected_answers [$];

   int  errors = 0;
   int  items_sent = 0;
   int  answers_seen = 0;
   int  adds_seen = 0, queries_seen = 0, empty_seen = 0, full_seen = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;

   function automatic int unsigned ring_slot(int unsigned k);
      return (hull_head + k) % MAX_LINES;
   endfunction

   // append one item to the stimulus list
   function automatic void stage_item(req_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   // true when crossing(b, new) lies at or left of crossing(a, b);
   // parallel lines cross at +infinity
   function automatic bit tail_covered(line_type a, line_type b,
                                       logic signed [31:0] m, logic signed [63:0] c);
      logic signed [64:0]  n1, n2;
      logic signed [32:0]  d1, d2;
      logic signed [129:0] lhs, rhs;
      d1 = $signed({m[31], m}) - $signed({b.slope[31], b.slope});
      d2 = $signed({b.slope[31], b.slope}) - $signed({a.slope[31], a.slope});
      if (d1 == 0) return d2 == 0;
      if (d2 == 0) return 1'b1;
      n1 = $signed({b.intercept[63], b.intercept}) - $signed({c[63], c});
      n2 = $signed({a.intercept[63], a.intercept}) - $signed({b.intercept[63], b.intercept});
      // make denominators positive so the fractions compare by cross products
      if (d1 < 0) begin
         d1 = -d1;
         n1 = -n1;
      end
      if (d2 < 0) begin
         d2 = -d2;
         n2 = -n2;
      end
      lhs = n1;
      rhs = n2;
      lhs = lhs * d2;
      rhs = rhs * d1;
      return lhs <= rhs;
   endfunction

   // exact (unwrapped) value of a line at x
   function automatic logic signed [127:0] line_at(line_type ln, logic signed [31:0] x);
      logic signed [127:0] s, xx, cc;
      s  = ln.slope;
      xx = x;
      cc = ln.intercept;
      return s * xx + cc;
   endfunction

   function automatic rsp_type hull_step(req_type it);
      rsp_type     r;
      int unsigned k;
      logic signed [127:0] v;
      r = '0;
      r.status = STATUS_OK;
      if (it.command == CMD_ADD) begin
         k = hull_count;
         while (k >= 2 && tail_covered(hull_lines[ring_slot(k - 2)],
                                       hull_lines[ring_slot(k - 1)],
                                       it.slope, it.intercept))
            k--;
         if (k >= MAX_LINES) begin
            r.status = STATUS_FULL;   // nothing changes
         end else begin
            hull_lines[ring_slot(k)] = '{slope: it.slope, intercept: it.intercept, tag: it.tag};
            hull_count = k + 1;
         end
      end else if (hull_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         // drop head lines while the next one is at least as high
         while (hull_count >= 2 &&
                line_at(hull_lines[ring_slot(0)], it.point) <=
                line_at(hull_lines[ring_slot(1)], it.point)) begin
            hull_head  = ring_slot(1);
            hull_count = hull_count - 1;
         end
         v = line_at(hull_lines[ring_slot(0)], it.point);
         r.best_value = v[63:0];
         r.best_tag   = hull_lines[ring_slot(0)].tag;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // item builders
   // ---------------------------------------------------------------------
   function automatic req_type add_item(logic signed [31:0] m, logic signed [63:0] c,
                                        logic signed [31:0] t);
      req_type it;
      it = '0;
      it.command   = CMD_ADD;
      it.slope     = m;
      it.intercept = c;
      it.tag       = t;
      it.point     = $urandom;   // ignored on adds, keeps its bits moving
      return it;
   endfunction

   function automatic req_type query_item(logic signed [31:0] x);
      req_type it;
      it = '0;
      it.command   = CMD_QUERY;
      it.point     = x;
      it.slope     = $urandom;
      it.intercept = {$urandom, $urandom};
      it.tag       = $urandom;
      return it;
   endfunction

   // mostly no gap, some short, a few long; occasional runs with no gaps at all
   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      longint cur_slope, cur_point, step;
      int     r;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;

      // empty store
      stage_item(query_item(32'sh8000_0000));
      // fill to capacity with lines m=k-512, c=-(k-512)^2: crossings grow, so nothing pops
      for (int k = 0; k < MAX_LINES; k++)
         stage_item(add_item(k - 512, -longint'((k - 512) * (k - 512)), k));
      // one more convex line: store full, rejected
      stage_item(add_item(512, -longint'(512 * 512), 32'sh7fff_ffff));
      // parallel to the tail: crossing at infinity keeps the tail, still full
      stage_item(add_item(511, 64'sh7fff_ffff_ffff_ffff, -7));
      // queries sweep the head forward
      stage_item(query_item(-1000));
      stage_item(query_item(0));
      stage_item(query_item(600));
      stage_item(query_item(32'sh7fff_ffff));
      // extremes of slope and intercept, wrap of the answer
      stage_item(add_item(32'sh7fff_ffff, 64'sh8000_0000_0000_0000, 32'sh8000_0000));
      stage_item(query_item(32'sh7fff_ffff));
      stage_item(add_item(32'sh7fff_ffff, 64'sh7fff_ffff_ffff_ffff, 1));
      stage_item(query_item(32'sh7fff_ffff));
      // decreasing point and unsorted slopes: no error, same steps
      stage_item(add_item(32'sh8000_0000, 0, 2));
      stage_item(add_item(-5, 64'sh8000_0000_0000_0000, 3));
      stage_item(query_item(32'sh8000_0000));
      stage_item(query_item(-3));
      stage_item(add_item(0, -1, -1));
      stage_item(add_item(0, -1, 4));
      stage_item(query_item(0));

      // random part: mostly monotone slopes and points, some noise
      cur_slope = -100000;
      cur_point = -100000;
      for (int n = 0; n < 60; n++) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            if ($urandom_range(0, 1))
               stage_item(add_item($urandom, {$urandom, $urandom}, $urandom));
            else
               stage_item(query_item($urandom));
         end else if (r < 60) begin
            step = ($urandom_range(0, 9) == 0) ? 0 :
                   ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1 << 24) :
                   $urandom_range(1, 300);
            cur_slope += step;
            if (cur_slope > 2147483647) cur_slope = -2147483648;
            if ($urandom_range(0, 4) == 0)
               stage_item(add_item(cur_slope, {$urandom, $urandom}, $urandom));
            else
               stage_item(add_item(cur_slope,
                  longint'($urandom_range(0, 2000000)) - 1000000 - cur_slope * cur_point,
                  $urandom));
         end else begin
            cur_point += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1 << 20) :
                         $urandom_range(0, 60);
            if (cur_point > 2147483647) cur_point = -2147483648;
            stage_item(query_item(cur_point));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && !req_ch.valid);
      wait (expected_answers.size() == 0);
      repeat (TAIL_WAIT) @(posedge clock);
      stimulus_done = 1'b1;
      $display("%0d items sent, %0d answers: %0d adds, %0d queries, %0d empty, %0d full",
               items_sent, answers_seen, adds_seen, queries_seen, empty_seen, full_seen);
      if (errors == 0 && expected_answers.size() == 0)
         $display("PASS monotone_convex_hull_trick");
      else
         $display("FAIL monotone_convex_hull_trick");
      $finish;
   end

   // ---------------------------------------------------------------------
   // driver: holds an item until taken, then a random gap
   // ---------------------------------------------------------------------
   int gap_left = 0;
   bit burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_answers.insert(expected_answers.size(), hull_step(req_ch.data));
            items_sent++;
            if ($urandom_range(0, 49) == 0) burst = !burst;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_ch.data  <= pending_items[0];
               pending_items.delete(0);
               req_ch.valid <= 1'b1;
               gap_left     <= pick_gap(burst);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stalls plus one long hold-off so the input backs up
   // ---------------------------------------------------------------------
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && answers_seen == 1060) begin
         long_hold_done = 1'b1;
         hold_left    <= 300;
         rsp_ch.ready <= 1'b0;
      end else if (burst) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 19))
            0:       hold_left <= $urandom_range(10, 40);
            1, 2, 3: hold_left <= $urandom_range(1, 3);
            default: ;
         endcase
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // ---------------------------------------------------------------------
   // monitor: compare each answer with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         answers_seen++;
         if (expected_answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected answer value=%0d tag=%0d status=%0d", $time,
                     rsp_ch.data.best_value, rsp_ch.data.best_tag, rsp_ch.data.status);
         end else begin
            want = expected_answers[0];
            expected_answers.delete(0);
            case (want.status)
               STATUS_EMPTY: empty_seen++;
               STATUS_FULL:  full_seen++;
               default:      if (want.best_tag == 0 && want.best_value == 0) adds_seen++;
                             else queries_seen++;
            endcase
            if (rsp_ch.data.best_value !== want.best_value) begin
               errors++;
               $display("%0t: best_value expected %0d got %0d", $time,
                        want.best_value, rsp_ch.data.best_value);
            end
            if (rsp_ch.data.best_tag !== want.best_tag) begin
               errors++;
               $display("%0t: best_tag expected %0d got %0d", $time,
                        want.best_tag, rsp_ch.data.best_tag);
            end
            if (rsp_ch.data.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d got %0d", $time,
                        want.status, rsp_ch.data.status);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (!stimulus_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d answers outstanding", $time, expected_answers.size());
            $display("FAIL monotone_convex_hull_trick");
            $finish;
         end
      end
   end
endmodule

@@ files.f @@
src/mcht_pkg.sv
src/mcht_if.sv
src/mcht_mul.sv
src/mcht_store.sv
src/monotone_convex_hull_trick.sv
test/monotone_convex_hull_trick_test.sv
